FILE: rtl/core/gaussian_reduce_by_two_top_defines.svh
`ifndef GAUSSIAN_REDUCE_BY_TWO_TOP_DEFINES_SVH
`define GAUSSIAN_REDUCE_BY_TWO_TOP_DEFINES_SVH

// Concurrent check on clk_i, off while rst_ni is low.
`define GRB2_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent check that a condition never holds.
`define GRB2_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: rtl/core/grb2_pkg.sv
package grb2_pkg;

  localparam int SIZE_W  = 12;
  localparam int PIX_W   = 8;
  localparam int CH_N    = 3;
  localparam int RGB_W   = PIX_W * CH_N;
  localparam int TDATA_W = RGB_W + PIX_W;
  localparam int TAPS    = 5;
  localparam int LINES   = 4;
  localparam int LINE_W  = $clog2(LINES);
  localparam int NORM_SH = 4;
  localparam int SUM_W   = PIX_W + NORM_SH;
  localparam int POS_W   = SIZE_W + 2;
  localparam int DIST_MAX = 4;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  localparam logic [2:0] TAP_WEIGHT [TAPS] = '{3'd1, 3'd4, 3'd6, 3'd4, 3'd1};

  typedef logic [SIZE_W-1:0]     size_t;
  typedef logic [PIX_W-1:0]      pix_t;
  typedef logic [RGB_W-1:0]      rgb_t;
  typedef rgb_t [TAPS-1:0]       taps_t;
  typedef logic [2:0]            dist_t;
  typedef dist_t [TAPS-1:0]      dists_t;
  typedef logic signed [POS_W-1:0] pos_t;

  typedef enum logic [0:0] {
    CFG_SOURCE_WIDTH  = 1'b0,
    CFG_SOURCE_HEIGHT = 1'b1
  } cfg_reg_e;

  // One horizontally positioned pixel, handed from the front end to the line stores.
  typedef struct packed {
    taps_t                hpix;
    size_t                x;
    logic                 emit;
    dists_t               vdist;
    logic [LINE_W-1:0]    line;
    logic                 row_even;
    pix_t                 alpha_wr;
    logic                 row_end;
    logic                 frame_end;
  } s1_t;

  // Distance back from the current position to tap m around center, mirrored at
  // both borders without repeating the edge sample, clamped to the held window.
  function automatic dist_t tap_offset(input size_t center, input logic [2:0] m,
                                       input size_t now, input size_t size);
    pos_t  k;
    pos_t  last_pos;
    pos_t  d;
    dist_t res;
    k        = pos_t'({2'b00, center}) + pos_t'({{(POS_W-3){1'b0}}, m}) - pos_t'(2);
    last_pos = pos_t'({2'b00, size}) - pos_t'(1);
    if (k < 0) k = -k;
    if (k > last_pos) k = last_pos + last_pos - k;
    d = pos_t'({2'b00, now}) - k;
    if (d < 0) begin
      res = '0;
    end else if (d > pos_t'(DIST_MAX)) begin
      res = dist_t'(DIST_MAX);
    end else begin
      res = d[2:0];
    end
    return res;
  endfunction

  // 1-4-6-4-1 kernel on each colour channel, sum truncated by 16.
  function automatic rgb_t weigh(input taps_t p);
    rgb_t              res;
    logic [SUM_W-1:0]  sum;
    res = '0;
    for (int ch = 0; ch < CH_N; ch++) begin
      sum = '0;
      for (int i = 0; i < TAPS; i++) begin
        sum = sum + SUM_W'(p[i][PIX_W*ch +: PIX_W]) * SUM_W'(TAP_WEIGHT[i]);
      end
      res[PIX_W*ch +: PIX_W] = sum[SUM_W-1 -: PIX_W];
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/grb2_ram.sv
module grb2_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 1024
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic                       re_i,
  input  logic [$clog2(DEPTH)-1:0]   addr_i,
  input  logic [DATA_W-1:0]          wdata_i,
  output logic [DATA_W-1:0]          rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/grb2_front.sv
`include "gaussian_reduce_by_two_top_defines.svh"

module grb2_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  grb2_pkg::size_t  w_i,
  input  grb2_pkg::size_t  h_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  grb2_pkg::rgb_t   in_rgb_i,
  input  grb2_pkg::pix_t   in_alpha_i,
  output logic             s1_valid_o,
  input  logic             s1_ready_i,
  output grb2_pkg::s1_t    s1_o
);

  grb2_pkg::size_t col_q, col_d, row_q, row_d;
  grb2_pkg::rgb_t  recent_q [4];
  grb2_pkg::pix_t  alpha_hold_q;
  logic            v1_q, v1_d;
  grb2_pkg::s1_t   s1_q, s1_d;
  logic            acc;
  grb2_pkg::size_t x, y, w_half, h_half, cx, cy;
  logic            x_hit, y_hit, x_ok, y_ok;

  assign in_ready_o = !v1_q || s1_ready_i;
  assign acc        = in_valid_i && in_ready_o;

  // Output position that the current source position completes, if any.
  always_comb begin
    w_half = w_i >> 1;
    h_half = h_i >> 1;
    x_hit  = 1'b0;
    x      = '0;
    if (!col_q[0] && col_q >= grb2_pkg::size_t'(2)) begin
      x_hit = 1'b1;
      x     = (col_q >> 1) - grb2_pkg::size_t'(1);
    end else if (col_q[0] && col_q == w_i - grb2_pkg::size_t'(1) && !w_i[0]) begin
      x_hit = 1'b1;
      x     = col_q >> 1;
    end
    y_hit = 1'b0;
    y     = '0;
    if (!row_q[0] && row_q >= grb2_pkg::size_t'(2)) begin
      y_hit = 1'b1;
      y     = (row_q >> 1) - grb2_pkg::size_t'(1);
    end else if (row_q[0] && row_q == h_i - grb2_pkg::size_t'(1) && !h_i[0]) begin
      y_hit = 1'b1;
      y     = row_q >> 1;
    end
    x_ok = x_hit && (x < w_half);
    y_ok = y_hit && (y < h_half);
    cx   = {x[grb2_pkg::SIZE_W-2:0], 1'b0};
    cy   = {y[grb2_pkg::SIZE_W-2:0], 1'b0};
  end

  // Select the five horizontal taps from the incoming pixel and the recent ones.
  always_comb begin
    grb2_pkg::dist_t hd;
    logic [1:0]      idx;
    s1_d = '0;
    for (int m = 0; m < grb2_pkg::TAPS; m++) begin
      hd  = grb2_pkg::tap_offset(cx, 3'(m), col_q, w_i);
      idx = 2'(hd - 3'd1);
      s1_d.hpix[m]  = (hd == '0) ? in_rgb_i : recent_q[idx];
      s1_d.vdist[m] = grb2_pkg::tap_offset(cy, 3'(m), row_q, h_i);
    end
    s1_d.x         = x;
    s1_d.emit      = y_ok;
    s1_d.line      = row_q[grb2_pkg::LINE_W-1:0];
    s1_d.row_even  = !row_q[0];
    s1_d.alpha_wr  = alpha_hold_q;
    s1_d.row_end   = (x == w_half - grb2_pkg::size_t'(1));
    s1_d.frame_end = s1_d.row_end && y_ok && (y == h_half - grb2_pkg::size_t'(1));
  end

  // Advance the raster position; wrap at the end of a row and of the frame.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (acc) begin
      if ((grb2_pkg::SIZE_W+1)'(col_q) + (grb2_pkg::SIZE_W+1)'(1) >=
          (grb2_pkg::SIZE_W+1)'(w_i)) begin
        col_d = '0;
        if ((grb2_pkg::SIZE_W+1)'(row_q) + (grb2_pkg::SIZE_W+1)'(1) >=
            (grb2_pkg::SIZE_W+1)'(h_i)) begin
          row_d = '0;
        end else begin
          row_d = row_q + grb2_pkg::size_t'(1);
        end
      end else begin
        col_d = col_q + grb2_pkg::size_t'(1);
      end
    end
  end

  always_comb begin
    v1_d = v1_q;
    if (acc && x_ok) begin
      v1_d = 1'b1;
    end else if (s1_ready_i) begin
      v1_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      v1_q         <= 1'b0;
      alpha_hold_q <= '0;
      for (int i = 0; i < 4; i++) begin
        recent_q[i] <= '0;
      end
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      v1_q  <= v1_d;
      if (acc) begin
        if (!col_q[0]) begin
          alpha_hold_q <= in_alpha_i;
        end
        recent_q[3] <= recent_q[2];
        recent_q[2] <= recent_q[1];
        recent_q[1] <= recent_q[0];
        recent_q[0] <= in_rgb_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && x_ok) begin
      s1_q <= s1_d;
    end
  end

  assign s1_valid_o = v1_q;
  assign s1_o       = s1_q;

  `GRB2_ASSERT(a_s1_x_bound, v1_q |-> (s1_q.x < (w_i >> 1)), "held column beyond output row")
  `GRB2_ASSERT(a_s1_frame_end, v1_q && s1_q.frame_end |-> s1_q.row_end && s1_q.emit, "bad frame end")
  `GRB2_ASSERT(a_col_wrap, acc && (col_q == w_i - grb2_pkg::size_t'(1)) |=> (col_q == '0), "no wrap")

endmodule

FILE: rtl/core/grb2_back.sv
`include "gaussian_reduce_by_two_top_defines.svh"

module grb2_back #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s1_valid_i,
  output logic            s1_ready_o,
  input  grb2_pkg::s1_t   s1_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output grb2_pkg::rgb_t  out_rgb_o,
  output grb2_pkg::pix_t  out_alpha_o,
  output logic            out_row_end_o,
  output logic            out_frame_end_o
);

  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int AW    = $clog2(DEPTH);

  logic                        mv1, adv2, ready3;
  logic [AW-1:0]               addr;
  grb2_pkg::rgb_t              hval;
  logic [grb2_pkg::LINES-1:0]  bank_we;
  grb2_pkg::rgb_t              bank_rd [grb2_pkg::LINES];
  grb2_pkg::pix_t              alpha_rd;

  logic                        v2_q, v2_d;
  grb2_pkg::rgb_t              hval_q;
  grb2_pkg::dists_t            vdist_q;
  logic [grb2_pkg::LINE_W-1:0] line_q;
  logic                        emit_q, row_end_q, frame_end_q;

  grb2_pkg::taps_t             vt;
  grb2_pkg::rgb_t              vres;

  logic                        out_valid_q, out_valid_d;
  grb2_pkg::rgb_t              out_rgb_q;
  grb2_pkg::pix_t              out_alpha_q;
  logic                        out_row_end_q, out_frame_end_q;

  assign ready3     = !out_valid_q || out_ready_i;
  assign adv2       = v2_q && (!emit_q || ready3);
  assign s1_ready_o = !v2_q || adv2;
  assign mv1        = s1_valid_i && s1_ready_o;

  assign hval = grb2_pkg::weigh(s1_i.hpix);
  assign addr = s1_i.x[AW-1:0];

  // Read all four lines and write this row's line in the same cycle; the
  // same-entry read sees the row four back, as the oldest tap needs.
  for (genvar b = 0; b < grb2_pkg::LINES; b++) begin : g_bank
    assign bank_we[b] = mv1 && (s1_i.line == grb2_pkg::LINE_W'(b));
    grb2_ram #(
      .DATA_W (grb2_pkg::RGB_W),
      .DEPTH  (DEPTH)
    ) u_line (
      .clk_i   (clk_i),
      .we_i    (bank_we[b]),
      .re_i    (mv1),
      .addr_i  (addr),
      .wdata_i (hval),
      .rdata_o (bank_rd[b])
    );
  end

  grb2_ram #(
    .DATA_W (grb2_pkg::PIX_W),
    .DEPTH  (DEPTH)
  ) u_alpha (
    .clk_i   (clk_i),
    .we_i    (mv1 && s1_i.row_even),
    .re_i    (mv1),
    .addr_i  (addr),
    .wdata_i (s1_i.alpha_wr),
    .rdata_o (alpha_rd)
  );

  always_comb begin
    logic [grb2_pkg::LINE_W-1:0] bsel;
    for (int m = 0; m < grb2_pkg::TAPS; m++) begin
      bsel  = grb2_pkg::LINE_W'(line_q - vdist_q[m][grb2_pkg::LINE_W-1:0]);
      vt[m] = (vdist_q[m] == '0) ? hval_q : bank_rd[bsel];
    end
    vres = grb2_pkg::weigh(vt);
  end

  always_comb begin
    v2_d = v2_q;
    if (mv1) begin
      v2_d = 1'b1;
    end else if (adv2) begin
      v2_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv2 && emit_q) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v2_q        <= v2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv1) begin
      hval_q      <= hval;
      vdist_q     <= s1_i.vdist;
      line_q      <= s1_i.line;
      emit_q      <= s1_i.emit;
      row_end_q   <= s1_i.row_end;
      frame_end_q <= s1_i.frame_end;
    end
    if (adv2 && emit_q) begin
      out_rgb_q       <= vres;
      out_alpha_q     <= alpha_rd;
      out_row_end_q   <= row_end_q;
      out_frame_end_q <= frame_end_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_rgb_o       = out_rgb_q;
  assign out_alpha_o     = out_alpha_q;
  assign out_row_end_o   = out_row_end_q;
  assign out_frame_end_o = out_frame_end_q;

  `GRB2_ASSERT(a_bank_we_onehot0, $onehot0(bank_we), "two line banks written at once")
  `GRB2_ASSERT(a_s2_hold, v2_q && emit_q && !ready3 |=> v2_q, "stalled result dropped")
  `GRB2_ASSERT_NEVER(a_frame_row, out_valid_q && out_frame_end_q && !out_row_end_q, "frame end off row")

endmodule

FILE: rtl/core/gaussian_reduce_by_two_top.sv
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/tready         source RGBA pixel, raster order
// m_axis    out  m_axis_tvalid/tready         half-size RGBA pixel, tlast, tuser
// cfg       in   cfg_valid_i/cfg_ready_o      register index, 12-bit size
//
// Sustained rate is one source pixel per clock while m_axis takes results; each request
// to the line stores reads all four banks and the alpha store and writes one line bank.
// A result passes the tap register and the line-store stage into the output register.
// Reset loads 640 x 480 (clamped to MAX_WIDTH) and returns to the frame start;
// the line stores need no clearing pass, so input is taken right after reset.
// A stalled m_axis fills the output register, then the line-store stage, then
// the tap stage, before s_axis_tready drops; empty stages always close up.
module gaussian_reduce_by_two_top #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [grb2_pkg::TDATA_W-1:0]      s_axis_tdata,  // red, green, blue, alpha
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [grb2_pkg::TDATA_W-1:0]      m_axis_tdata,  // out_red, out_green, out_blue,
                                                           // out_alpha
  output logic                              m_axis_tlast,  // row_end
  output logic [0:0]                        m_axis_tuser,  // frame_end
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [0:0]                        cfg_index_i,
  input  logic [grb2_pkg::SIZE_W-1:0]       cfg_data_i
);

  // Reset sizes, clamped the same way as a written value.
  localparam grb2_pkg::size_t W_RESET = grb2_pkg::size_t'(
    (grb2_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : grb2_pkg::RESET_WIDTH);
  localparam grb2_pkg::size_t H_RESET = grb2_pkg::size_t'(
    (grb2_pkg::RESET_HEIGHT > MAX_WIDTH) ? MAX_WIDTH : grb2_pkg::RESET_HEIGHT);

  grb2_pkg::size_t w_q, w_d, h_q, h_d, cfg_size;
  logic            s1_valid, s1_ready;
  grb2_pkg::s1_t   s1;
  grb2_pkg::rgb_t  out_rgb;
  grb2_pkg::pix_t  out_alpha;
  logic            out_row_end, out_frame_end;

  // Config writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Hold the effective size: zero acts as one, anything above MAX_WIDTH as MAX_WIDTH.
  always_comb begin
    cfg_size = cfg_data_i;
    if (cfg_data_i == '0) begin
      cfg_size = grb2_pkg::size_t'(1);
    end else if (int'(cfg_data_i) > MAX_WIDTH) begin
      cfg_size = grb2_pkg::size_t'(MAX_WIDTH);
    end
    w_d = w_q;
    h_d = h_q;
    if (cfg_valid_i) begin
      unique case (grb2_pkg::cfg_reg_e'(cfg_index_i))
        grb2_pkg::CFG_SOURCE_WIDTH:  w_d = cfg_size;
        grb2_pkg::CFG_SOURCE_HEIGHT: h_d = cfg_size;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= W_RESET;
      h_q <= H_RESET;
    end else begin
      w_q <= w_d;
      h_q <= h_d;
    end
  end

  // Front end: raster counters, recent pixels and tap selection for each request.
  grb2_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .w_i        (w_q),
    .h_i        (h_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_rgb_i   (s_axis_tdata[grb2_pkg::RGB_W-1:0]),
    .in_alpha_i (s_axis_tdata[grb2_pkg::RGB_W +: grb2_pkg::PIX_W]),
    .s1_valid_o (s1_valid),
    .s1_ready_i (s1_ready),
    .s1_o       (s1)
  );

  // Back end: horizontal sum, line-store read and write, vertical sum, output register.
  grb2_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s1_valid_i      (s1_valid),
    .s1_ready_o      (s1_ready),
    .s1_i            (s1),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_rgb_o       (out_rgb),
    .out_alpha_o     (out_alpha),
    .out_row_end_o   (out_row_end),
    .out_frame_end_o (out_frame_end)
  );

  assign m_axis_tdata = {out_alpha, out_rgb};
  assign m_axis_tlast = out_row_end;
  assign m_axis_tuser = out_frame_end;

endmodule

FILE: test/gaussian_reduce_by_two_checker.sv
`timescale 1ns / 100ps

module gaussian_reduce_by_two_checker #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [grb2_pkg::TDATA_W-1:0] s_axis_tdata,   // red, green, blue, alpha
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [grb2_pkg::TDATA_W-1:0] m_axis_tdata,   // out_red, out_green, out_blue,
                                                       // out_alpha
  input  logic                         m_axis_tlast,   // row_end
  input  logic [0:0]                   m_axis_tuser,   // frame_end
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_o,
  input  logic [0:0]                   cfg_index_i,
  input  logic [grb2_pkg::SIZE_W-1:0]  cfg_data_i,
  output int                           fail_count_o,
  output int                           pending_o
);

  localparam int SLOTS = MAX_WIDTH / 2;
  localparam int KW [5] = '{1, 4, 6, 4, 1};

  typedef struct {
    grb2_pkg::pix_t red;
    grb2_pkg::pix_t green;
    grb2_pkg::pix_t blue;
    grb2_pkg::pix_t alpha;
    logic           row_end;
    logic           frame_end;
  } half_pixel_t;

  grb2_pkg::size_t width_reg;
  grb2_pkg::size_t height_reg;
  int              col;
  int              row;
  grb2_pkg::rgb_t  recent [4];
  grb2_pkg::rgb_t  hline [grb2_pkg::LINES][SLOTS];
  grb2_pkg::pix_t  aline [SLOTS];
  grb2_pkg::pix_t  alpha_keep;
  half_pixel_t     reduced_q [$];
  int              fails;

  function automatic int eff_size(input grb2_pkg::size_t v);
    if (v < 1) return 1;
    if (v > MAX_WIDTH) return MAX_WIDTH;
    return int'(v);
  endfunction

  // Mirror about both borders, edge sample not repeated.
  function automatic int reflect(input int k, input int n);
    if (k < 0) k = -k;
    if (k > n - 1) k = 2 * (n - 1) - k;
    return k;
  endfunction

  function automatic int hold_lag(input int d);
    if (d < 0) return 0;
    if (d > 4) return 4;
    return d;
  endfunction

  function automatic grb2_pkg::rgb_t binomial(input grb2_pkg::rgb_t t [5]);
    grb2_pkg::rgb_t res;
    int             s;
    res = '0;
    for (int ch = 0; ch < grb2_pkg::CH_N; ch++) begin
      s = 0;
      for (int i = 0; i < 5; i++) begin
        s += KW[i] * int'(t[i][grb2_pkg::PIX_W*ch +: grb2_pkg::PIX_W]);
      end
      res[grb2_pkg::PIX_W*ch +: grb2_pkg::PIX_W] = grb2_pkg::pix_t'(s / 16);
    end
    return res;
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    fails++;
  endtask

  // Advance the frame position by one source pixel, queue the half-size pixel it completes.
  task automatic take_pixel(input logic [grb2_pkg::TDATA_W-1:0] d);
    int             w;
    int             h;
    int             x;
    int             y;
    int             lag;
    int             ln;
    grb2_pkg::rgb_t cur;
    grb2_pkg::rgb_t hsum;
    grb2_pkg::rgb_t vsum;
    grb2_pkg::pix_t a;
    grb2_pkg::rgb_t hp [5];
    grb2_pkg::rgb_t vp [5];
    half_pixel_t    o;
    w    = eff_size(width_reg);
    h    = eff_size(height_reg);
    cur  = d[grb2_pkg::RGB_W-1:0];
    a    = d[grb2_pkg::TDATA_W-1 -: grb2_pkg::PIX_W];
    x    = -1;
    if (col % 2 == 0 && col >= 2) x = col / 2 - 1;
    else if (col % 2 == 1 && col == w - 1 && w % 2 == 0) x = (col - 1) / 2;
    if (x >= 0 && x < w / 2) begin
      for (int m = 0; m < 5; m++) begin
        lag   = hold_lag(col - reflect(2 * x + m - 2, w));
        hp[m] = (lag == 0) ? cur : recent[(lag - 1) & 3];
      end
      hsum = binomial(hp);
      y = -1;
      if (row % 2 == 0 && row >= 2) y = row / 2 - 1;
      else if (row % 2 == 1 && row == h - 1 && h % 2 == 0) y = (row - 1) / 2;
      if (y >= 0 && y < h / 2) begin
        for (int m = 0; m < 5; m++) begin
          lag   = hold_lag(row - reflect(2 * y + m - 2, h));
          ln    = (row - lag) & 3;
          vp[m] = (lag == 0) ? hsum : hline[ln][x];
        end
        vsum        = binomial(vp);
        o.red       = vsum[7:0];
        o.green     = vsum[15:8];
        o.blue      = vsum[23:16];
        o.alpha     = aline[x];
        o.row_end   = (x == w / 2 - 1);
        o.frame_end = o.row_end && (y == h / 2 - 1);
        reduced_q.push_back(o);
      end
      hline[row & 3][x] = hsum;
      if (row % 2 == 0) aline[x] = alpha_keep;
    end
    if (col % 2 == 0) alpha_keep = a;
    recent[3] = recent[2];
    recent[2] = recent[1];
    recent[1] = recent[0];
    recent[0] = cur;
    if (col + 1 >= w) begin
      col = 0;
      row = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
  endtask

  task automatic check_result();
    half_pixel_t o;
    if (reduced_q.size() == 0) begin
      note_mismatch("result with nothing expected, tdata", int'(m_axis_tdata), -1);
    end else begin
      o = reduced_q.pop_front();
      if (m_axis_tdata[7:0] !== o.red) note_mismatch("red", m_axis_tdata[7:0], o.red);
      if (m_axis_tdata[15:8] !== o.green) note_mismatch("green", m_axis_tdata[15:8], o.green);
      if (m_axis_tdata[23:16] !== o.blue) note_mismatch("blue", m_axis_tdata[23:16], o.blue);
      if (m_axis_tdata[31:24] !== o.alpha) note_mismatch("alpha", m_axis_tdata[31:24], o.alpha);
      if (m_axis_tlast !== o.row_end) note_mismatch("row_end", m_axis_tlast, o.row_end);
      if (m_axis_tuser[0] !== o.frame_end) note_mismatch("frame_end", m_axis_tuser, o.frame_end);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  = grb2_pkg::size_t'(grb2_pkg::RESET_WIDTH);
      height_reg = grb2_pkg::size_t'(grb2_pkg::RESET_HEIGHT);
      col        = 0;
      row        = 0;
      alpha_keep = '0;
      fails      = 0;
      for (int i = 0; i < 4; i++) recent[i] = '0;
      for (int i = 0; i < grb2_pkg::LINES; i++) begin
        for (int j = 0; j < SLOTS; j++) hline[i][j] = '0;
      end
      for (int j = 0; j < SLOTS; j++) aline[j] = '0;
      reduced_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == grb2_pkg::CFG_SOURCE_WIDTH) width_reg = cfg_data_i;
        else height_reg = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) take_pixel(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_result();
    end
    fail_count_o <= fails;
    pending_o    <= reduced_q.size();
  end

endmodule

FILE: test/tb_gaussian_reduce_by_two_top.sv
`timescale 1ns / 100ps

module tb_gaussian_reduce_by_two_top;

  localparam int MAX_WIDTH     = 2048;
  localparam int RANDOM_PIXELS = 1200;
  localparam int QUIET_TAIL    = 250;    // last random pixels run with no idling
  localparam int SETTLE_CYCLES = 8;      // covers the pipeline behind the last result
  localparam int END_WAIT_MAX  = 200000;

  logic                         clk_i;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [grb2_pkg::TDATA_W-1:0] s_axis_tdata  = '0;   // red, green, blue, alpha
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [grb2_pkg::TDATA_W-1:0] m_axis_tdata;         // out_red, out_green, out_blue,
                                                      // out_alpha
  logic                         m_axis_tlast;         // row_end
  logic [0:0]                   m_axis_tuser;         // frame_end
  logic                         cfg_valid_i   = 1'b0;
  logic                         cfg_ready_o;
  logic [0:0]                   cfg_index_i   = '0;
  logic [grb2_pkg::SIZE_W-1:0]  cfg_data_i    = '0;

  int fail_count;
  int pending;

  // Mirror of the frame position, so stimulus knows where a frame starts.
  int ew = grb2_pkg::RESET_WIDTH;
  int eh = grb2_pkg::RESET_HEIGHT;
  int col_pos = 0;
  int row_pos = 0;
  int sent = 0;
  bit no_idle = 1'b0;

  gaussian_reduce_by_two_top #(
    .MAX_WIDTH(MAX_WIDTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  gaussian_reduce_by_two_checker #(
    .MAX_WIDTH(MAX_WIDTH)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Hard stop: several times the slowest legal run (about 1.5k pixels, each
  // with a full sender gap and a full result stall).
  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

  // Result side: ready stretches, some long, broken by stall bursts;
  // hold ready high once the quiet tail starts.
  initial begin
    @(posedge clk_i);
    forever begin
      m_axis_tready <= 1'b1;
      repeat (($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 30)) @(posedge clk_i);
      if (!no_idle) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
  end

  function automatic int fit(input int v);
    return (v < 1) ? 1 : ((v > MAX_WIDTH) ? MAX_WIDTH : v);
  endfunction

  // Random pixel, each channel sometimes forced to 0 or 255.
  function automatic logic [grb2_pkg::TDATA_W-1:0] pick_pixel();
    logic [grb2_pkg::TDATA_W-1:0] p;
    p = $urandom;
    for (int b = 0; b < 4; b++) begin
      case ($urandom_range(0, 7))
        0:       p[8*b +: 8] = '0;
        1:       p[8*b +: 8] = '1;
        default: ;
      endcase
    end
    return p;
  endfunction

  // Extreme channel values in a short repeating pattern.
  function automatic logic [grb2_pkg::TDATA_W-1:0] corner_pixel(input int n);
    case (n % 4)
      0:       return '0;
      1:       return '1;
      2:       return 32'h00ff_00ff;
      default: return 32'hff00_ff00;
    endcase
  endfunction

  // Issue one pixel request, maybe after an idle burst; return at its accept edge.
  task automatic send_pixel(input logic [grb2_pkg::TDATA_W-1:0] pix);
    if (!no_idle && $urandom_range(0, 11) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
    if (col_pos + 1 >= ew) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= eh) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  // Drop valid, wait out every pending result, then let the pipeline empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both size registers back to back; valid stays high between requests.
  task automatic program_size(input int w, input int h);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= grb2_pkg::CFG_SOURCE_WIDTH;
    cfg_data_i  <= grb2_pkg::size_t'(w);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= grb2_pkg::CFG_SOURCE_HEIGHT;
    cfg_data_i  <= grb2_pkg::size_t'(h);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    ew = fit(w);
    eh = fit(h);
  endtask

  // Send pixels until the position wraps back to the frame start.
  task automatic finish_frame(input bit extremes);
    int n;
    n = 0;
    do begin
      send_pixel(extremes ? corner_pixel(n) : pick_pixel());
      n++;
    end while (col_pos != 0 || row_pos != 0);
  endtask

  initial begin : stimulus
    int base;
    int nw;
    int nh;
    int guard;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);

    // Start a frame at the reset size, then shrink it mid-frame: the column
    // counter is past the new width and wraps into row one.
    for (int i = 0; i < 8; i++) send_pixel(corner_pixel(i));
    settle();
    program_size(4, 4);
    finish_frame(1'b1);
    // Smallest frame with output, all channels at full scale.
    settle();
    program_size(2, 2);
    repeat (4) send_pixel('1);
    // Zero sizes act as one: no output at all.
    settle();
    program_size(0, 0);
    finish_frame(1'b1);

    // Oversized values clamp to MAX_WIDTH: start a wide row, then shrink the
    // frame so the column counter is past the new width and wraps.
    settle();
    program_size(4095, 4095);
    repeat (40) send_pixel(pick_pixel());
    settle();
    program_size(8, 4);
    finish_frame(1'b0);
    // Narrow tall frame: run deep rows, then cut the height so the frame ends there.
    settle();
    program_size(2, 4095);
    repeat (40) send_pixel(pick_pixel());
    settle();
    program_size(2, 24);
    finish_frame(1'b0);

    // Random frames: mostly complete, some cut short and resized mid-frame.
    base = sent;
    while (sent - base < RANDOM_PIXELS) begin
      if (sent - base > RANDOM_PIXELS - QUIET_TAIL) no_idle = 1'b1;
      if (no_idle) begin
        // Quiet tail: keep the current size and stream whole frames without gaps.
        finish_frame(1'b0);
      end else begin
        settle();
        if ($urandom_range(0, 9) == 0) begin
          nw = $urandom_range(0, 4);
          nh = $urandom_range(0, 4);
        end else begin
          nw = $urandom_range(4, 24);
          nh = $urandom_range(4, 10);
        end
        program_size(nw, nh);
        if ($urandom_range(0, 5) == 0 && ew * eh > 1) begin
          // Never widen mid-frame: that would read line-store slots not yet written.
          repeat ($urandom_range(1, ew * eh - 1)) send_pixel(pick_pixel());
          settle();
          program_size($urandom_range(0, ew), $urandom_range(0, 12));
          finish_frame(1'b0);
        end else begin
          repeat ($urandom_range(1, 3)) finish_frame(1'b0);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    guard = 0;
    @(posedge clk_i);
    while (pending != 0 && guard < END_WAIT_MAX) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4 * SETTLE_CYCLES) @(posedge clk_i);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
